// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/ttc_pkg.sv =====
// Types and constants of the triple timer counter unit.
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

  localparam int OpW     = 3;
  localparam int IdxW    = 2;
  localparam int DataW   = 16;
  localparam int ModeW   = 10;
  localparam int IrqW    = 3;
  localparam int CfgIdxW = 1;

  localparam int NUM_TIMERS_DEF   = 3;
  localparam int SLOW_DIVIDER_DEF = 8;

  localparam logic [DataW-1:0] DOT_DIV_RST  = 16'd5;
  localparam logic [DataW-1:0] LINE_DIV_RST = 16'd2146;
  localparam logic [DataW-1:0] FULL_COUNT   = 16'hffff;

  localparam int ModeHaltBit   = 0;
  localparam int ModeTargetBit = 4;
  localparam int ModeFullBit   = 5;
  localparam int ModeRepeatBit = 6;
  localparam int ModeClkLsb    = 8;

  localparam logic [1:0] CLK_ALT  = 2'b01;
  localparam logic [1:0] CLK_SLOW = 2'b10;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 3'd0,
    OP_WR_COUNT  = 3'd1,
    OP_WR_MODE   = 3'd2,
    OP_WR_TARGET = 3'd3,
    OP_RD_COUNT  = 3'd4
  } ttc_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOT_DIV  = 1'b0,
    CFG_LINE_DIV = 1'b1
  } ttc_cfg_e;

  typedef struct packed {
    logic             tick;
    logic             wr_count;
    logic             wr_mode;
    logic             wr_target;
    logic [DataW-1:0] value;
  } ttc_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ttc_timer.sv =====
// One timer: count, target, mode, prescaler and arm flag with their update logic.
`timescale 1ns / 1ps
`default_nettype none

module ttc_timer #(
  parameter int TIMER_ID     = 0,
  parameter int SLOW_DIVIDER = ttc_pkg::SLOW_DIVIDER_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      sel_i,
  input  wire ttc_pkg::ttc_cmd_t         cmd_i,
  input  wire logic [ttc_pkg::DataW-1:0] alt_div_i,
  output logic      [ttc_pkg::DataW-1:0] count_o,
  output logic                           irq_o
);
  import ttc_pkg::*;

  logic [DataW-1:0] count_q, count_d;
  logic [DataW-1:0] presc_q, presc_d;
  logic [DataW-1:0] target_q, target_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic             armed_q, armed_d;

  logic [1:0]       clk_sel;
  logic [DataW-1:0] rate_raw;
  logic [DataW-1:0] rate;
  logic             halt;
  logic [DataW:0]   presc_inc;
  logic [DataW-1:0] count_step;
  logic [DataW-1:0] limit;

  always_comb begin
    clk_sel  = mode_q[ModeClkLsb +: 2];
    rate_raw = DataW'(1);
    if ((TIMER_ID == 0 || TIMER_ID == 1) && clk_sel == CLK_ALT) begin
      rate_raw = alt_div_i;
    end else if (TIMER_ID == 2 && clk_sel == CLK_SLOW) begin
      rate_raw = DataW'(SLOW_DIVIDER);
    end
    rate = (rate_raw == '0) ? DataW'(1) : rate_raw;
    halt = (TIMER_ID == 2) && mode_q[ModeHaltBit];
  end

  assign presc_inc  = {1'b0, presc_q} + (DataW+1)'(1);
  assign count_step = count_q + DataW'(1);
  assign limit      = mode_q[ModeTargetBit] ? target_q : FULL_COUNT;

  always_comb begin
    count_d  = count_q;
    presc_d  = presc_q;
    target_d = target_q;
    mode_d   = mode_q;
    armed_d  = armed_q;
    irq_o    = 1'b0;
    if (en_i) begin
      if (cmd_i.tick) begin
        if (!halt) begin
          if (presc_inc < {1'b0, rate}) begin
            presc_d = presc_inc[DataW-1:0];
          end else begin
            presc_d = '0;
            count_d = count_step;
            if (armed_q && (mode_q[ModeTargetBit] || mode_q[ModeFullBit]) &&
                count_step == limit) begin
              count_d = '0;
              irq_o   = 1'b1;
              if (!mode_q[ModeRepeatBit]) begin
                armed_d = 1'b0;
              end
            end
          end
        end
      end else if (sel_i && (cmd_i.wr_count || cmd_i.wr_mode || cmd_i.wr_target)) begin
        armed_d = 1'b1;
        presc_d = '0;
        if (cmd_i.wr_count) begin
          count_d = cmd_i.value;
        end
        if (cmd_i.wr_mode) begin
          mode_d  = cmd_i.value[ModeW-1:0];
          count_d = '0;
        end
        if (cmd_i.wr_target) begin
          target_d = cmd_i.value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      presc_q  <= '0;
      target_q <= '0;
      mode_q   <= '0;
      armed_q  <= 1'b1;
    end else begin
      count_q  <= count_d;
      presc_q  <= presc_d;
      target_q <= target_d;
      mode_q   <= mode_d;
      armed_q  <= armed_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== hdl/triple_timer_counter_unit.sv =====
// Top level of the triple timer counter unit: beat registers, decode and timer slices.
// Each accepted beat is captured in the input register, then its result in the result register
// once the output is free; one beat is accepted every cycle while the output is not stalled.
// Every item, tick or access, is handled in one pass through the timer update logic.
// Reset clears all counts, modes, targets and prescalers, arms every timer and loads
// the dot and line dividers with 5 and 2146; the unit accepts beats straight after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triple_timer_counter_unit #(
  parameter int NUM_TIMERS   = ttc_pkg::NUM_TIMERS_DEF,
  parameter int SLOW_DIVIDER = ttc_pkg::SLOW_DIVIDER_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ttc_pkg::OpW-1:0]     mode_i,
  input  wire logic [ttc_pkg::IdxW-1:0]    counter_index_i,
  input  wire logic [ttc_pkg::DataW-1:0]   write_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [ttc_pkg::DataW-1:0]   read_data_o,
  output logic      [ttc_pkg::IrqW-1:0]    irq_pulses_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ttc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ttc_pkg::DataW-1:0]   cfg_data_i
);
  import ttc_pkg::*;

  logic [DataW-1:0] dot_div_q, line_div_q;

  logic             in_valid_q;
  logic [OpW-1:0]   op_q;
  logic [IdxW-1:0]  idx_q;
  logic [DataW-1:0] val_q;

  logic             out_valid_q;
  logic [DataW-1:0] rd_q, rd_d;
  logic [IrqW-1:0]  irq_q, irq_d;

  logic             out_free;
  logic             fire;
  logic             in_load;
  ttc_cmd_t         cmd;

  logic [DataW-1:0] counts [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tirq;
  logic [NUM_TIMERS-1:0] tsel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_div_q  <= DOT_DIV_RST;
      line_div_q <= LINE_DIV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ttc_cfg_e'(cfg_index_i))
        CFG_DOT_DIV:  dot_div_q  <= cfg_data_i;
        CFG_LINE_DIV: line_div_q <= cfg_data_i;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_load    = !in_valid_q || fire;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      op_q  <= mode_i;
      idx_q <= counter_index_i;
      val_q <= write_value_i;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.value     = val_q;
    unique case (op_q)
      OP_TICK:      cmd.tick      = 1'b1;
      OP_WR_COUNT:  cmd.wr_count  = 1'b1;
      OP_WR_MODE:   cmd.wr_mode   = 1'b1;
      OP_WR_TARGET: cmd.wr_target = 1'b1;
      default:      cmd.tick      = 1'b0;
    endcase
  end

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    logic [DataW-1:0] alt_div;
    assign tsel[t]  = (int'(idx_q) == t);
    assign alt_div  = (t == 0) ? dot_div_q : ((t == 1) ? line_div_q : '0);

    ttc_timer #(
      .TIMER_ID     (t),
      .SLOW_DIVIDER (SLOW_DIVIDER)
    ) u_timer (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (fire),
      .sel_i     (tsel[t]),
      .cmd_i     (cmd),
      .alt_div_i (alt_div),
      .count_o   (counts[t]),
      .irq_o     (tirq[t])
    );
  end

  always_comb begin
    rd_d = '0;
    if (op_q == OP_RD_COUNT) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (tsel[t]) begin
          rd_d = counts[t];
        end
      end
    end
  end

  for (genvar b = 0; b < IrqW; b++) begin : g_irq
    if (b < NUM_TIMERS) begin : g_live
      assign irq_d[b] = tirq[b];
    end else begin : g_none
      assign irq_d[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = rd_q;
  assign irq_pulses_o = irq_q;

  `ASSERT_CLK_RST(a_irq_only_on_tick, clk_i, rst_ni, fire && op_q != OP_TICK |=> irq_pulses_o == '0, "interrupt raised by a non-tick beat")
  `ASSERT_CLK_RST(a_data_only_on_read, clk_i, rst_ni, fire && op_q != OP_RD_COUNT |=> read_data_o == '0, "read data on a non-read beat")
  `ASSERT_CLK_RST(a_hold_blocked_beat, clk_i, rst_ni, in_valid_q && !out_free |=> in_valid_q && $stable(op_q) && $stable(val_q), "blocked beat lost or changed")
  `ASSERT_CLK(a_cfg_always_ready, clk_i, cfg_ready_o, "configuration port not ready")

endmodule

`default_nettype wire

// ===== dv/triple_timer_counter_unit_tb.sv =====
// Self-checking testbench for the triple timer counter unit: directed table, then random timer runs.
`timescale 1ns / 1ps

module triple_timer_counter_unit_tb;
  import ttc_pkg::*;

  localparam int Timers = NUM_TIMERS_DEF;
  localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_LAST = 3'd7;
  localparam logic [IdxW-1:0] IDX_ABSENT = 2'd3;
  localparam int PhaseBeats = 130;

  typedef struct packed {
    logic [DataW-1:0] rd;
    logic [IrqW-1:0]  irq;
  } timer_result_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] val;
    logic             typed;
    logic [DataW-1:0] rd;
    logic [IrqW-1:0]  irq;
  } dir_row_t;

  localparam dir_row_t DirRows [25] = '{
    '{OP_RD_COUNT,    2'd0,       16'h0000, 1'b1, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    2'd2,       16'h0000, 1'b1, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    IDX_ABSENT, 16'h0000, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_COUNT,    2'd0,       16'hffff, 1'b1, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    2'd0,       16'h0000, 1'b1, 16'hffff, 3'b000},
    '{OP_TICK,        2'd0,       16'h0000, 1'b0, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    2'd0,       16'h0000, 1'b0, 16'h0000, 3'b000},
    '{OP_WR_TARGET,   2'd1,       16'h0002, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_MODE,     2'd1,       16'h0050, 1'b1, 16'h0000, 3'b000},
    '{OP_TICK,        2'd3,       16'hffff, 1'b0, 16'h0000, 3'b000},
    '{OP_TICK,        2'd1,       16'h0000, 1'b0, 16'h0000, 3'b000},
    '{OP_WR_MODE,     2'd2,       16'h0201, 1'b1, 16'h0000, 3'b000},
    '{OP_TICK,        2'd2,       16'h0000, 1'b0, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    2'd2,       16'h0000, 1'b0, 16'h0000, 3'b000},
    '{OP_WR_MODE,     2'd0,       16'h0120, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_COUNT,    2'd0,       16'hfffe, 1'b1, 16'h0000, 3'b000},
    '{OP_SPARE_FIRST, 2'd0,       16'hffff, 1'b1, 16'h0000, 3'b000},
    '{OP_SPARE_LAST,  IDX_ABSENT, 16'hffff, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_COUNT,    IDX_ABSENT, 16'habcd, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_MODE,     IDX_ABSENT, 16'h03ff, 1'b1, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    IDX_ABSENT, 16'h0000, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_MODE,     2'd0,       16'hffff, 1'b1, 16'h0000, 3'b000},
    '{OP_RD_COUNT,    2'd0,       16'h0000, 1'b1, 16'h0000, 3'b000},
    '{OP_WR_TARGET,   2'd2,       16'hffff, 1'b1, 16'h0000, 3'b000},
    '{OP_TICK,        2'd0,       16'h0000, 1'b0, 16'h0000, 3'b000}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OpW-1:0]      mode_i = OP_TICK;
  logic [IdxW-1:0]     counter_index_i = '0;
  logic [DataW-1:0]    write_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DataW-1:0]    read_data_o;
  logic [IrqW-1:0]     irq_pulses_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_DOT_DIV;
  logic [DataW-1:0]    cfg_data_i = '0;

  logic [DataW-1:0] tmr_count [Timers];
  logic [DataW-1:0] tmr_prescale [Timers];
  logic [ModeW-1:0] tmr_mode [Timers];
  logic [DataW-1:0] tmr_target [Timers];
  logic             tmr_armed [Timers];
  logic [DataW-1:0] dot_div = DOT_DIV_RST;
  logic [DataW-1:0] line_div = LINE_DIV_RST;

  timer_result_t pending_results [$];
  int unsigned   beats_sent = 0;
  int unsigned   reads_sent = 0;
  int unsigned   irq_beats = 0;
  int unsigned   results_seen = 0;
  int unsigned   errors = 0;
  int unsigned   hold_cycles = 0;
  bit            quiet = 1'b0;

  triple_timer_counter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .counter_index_i(counter_index_i),
    .write_value_i  (write_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .irq_pulses_o   (irq_pulses_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void step_timers(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                                      input logic [DataW-1:0] val,
                                      output logic [DataW-1:0] rd, output logic [IrqW-1:0] irq);
    int t;
    int unsigned rate;
    logic [DataW-1:0] limit;
    rd = '0;
    irq = '0;
    if (op == OP_TICK) begin
      for (t = 0; t < Timers; t++) begin
        if (t == 2 && tmr_mode[t][ModeHaltBit]) continue;
        rate = 1;
        if (t == 0 && tmr_mode[t][ModeClkLsb +: 2] == CLK_ALT) rate = dot_div;
        else if (t == 1 && tmr_mode[t][ModeClkLsb +: 2] == CLK_ALT) rate = line_div;
        else if (t == 2 && tmr_mode[t][ModeClkLsb +: 2] == CLK_SLOW) rate = SLOW_DIVIDER_DEF;
        if (rate == 0) rate = 1;
        if (32'(tmr_prescale[t]) + 1 < rate) begin
          tmr_prescale[t] = tmr_prescale[t] + 1'b1;
          continue;
        end
        tmr_prescale[t] = '0;
        tmr_count[t] = tmr_count[t] + 1'b1;
        if (!tmr_armed[t] || !(tmr_mode[t][ModeTargetBit] || tmr_mode[t][ModeFullBit])) continue;
        limit = tmr_mode[t][ModeTargetBit] ? tmr_target[t] : FULL_COUNT;
        if (tmr_count[t] != limit) continue;
        tmr_count[t] = '0;
        if (!tmr_mode[t][ModeRepeatBit]) tmr_armed[t] = 1'b0;
        irq[t] = 1'b1;
      end
    end else if (idx < Timers) begin
      case (op)
        OP_WR_COUNT, OP_WR_MODE, OP_WR_TARGET: begin
          tmr_armed[idx] = 1'b1;
          tmr_prescale[idx] = '0;
          if (op == OP_WR_COUNT) begin
            tmr_count[idx] = val;
          end else if (op == OP_WR_MODE) begin
            tmr_mode[idx] = val[ModeW-1:0];
            tmr_count[idx] = '0;
          end else begin
            tmr_target[idx] = val;
          end
        end
        OP_RD_COUNT: rd = tmr_count[idx];
        default: ;
      endcase
    end
  endfunction

  task automatic offer_beat(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                            input logic [DataW-1:0] val, input logic typed = 1'b0,
                            input timer_result_t typed_res = '0);
    int unsigned gap;
    timer_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= op;
    counter_index_i <= idx;
    write_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    step_timers(op, idx, val, res.rd, res.irq);
    pending_results.push_back(typed ? typed_res : res);
    beats_sent++;
    if (op == OP_RD_COUNT) reads_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dividers(input logic [DataW-1:0] dot, input logic [DataW-1:0] line);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DOT_DIV;
    cfg_data_i <= dot;
    do @(posedge clk_i); while (!cfg_ready_o);
    dot_div = dot;
    cfg_index_i <= CFG_LINE_DIV;
    cfg_data_i <= line;
    do @(posedge clk_i); while (!cfg_ready_o);
    line_div = line;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [IdxW-1:0] pick_index();
    return ($urandom_range(0, 15) == 0) ? IDX_ABSENT : IdxW'($urandom_range(0, Timers - 1));
  endfunction

  function automatic logic [DataW-1:0] pick_mode();
    logic [DataW-1:0] m;
    m = 16'($urandom);
    if ($urandom_range(0, 3) != 0) m[ModeTargetBit] = 1'b1;
    if ($urandom_range(0, 3) != 0) m[ModeHaltBit] = 1'b0;
    return m;
  endfunction

  task automatic offer_noise_beat();
    int unsigned pick;
    logic [OpW-1:0] op;
    logic [DataW-1:0] val;
    pick = $urandom_range(0, 99);
    val = 16'($urandom);
    if (pick < 50) op = OP_TICK;
    else if (pick < 60) op = OP_WR_COUNT;
    else if (pick < 68) begin
      op = OP_WR_MODE;
      val = pick_mode();
    end else if (pick < 76) op = OP_WR_TARGET;
    else if (pick < 94) op = OP_RD_COUNT;
    else op = OpW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    offer_beat(op, pick_index(), val);
  endtask

  // program one timer, often close to its limit, then tick it through
  task automatic run_timer_scenario();
    logic [IdxW-1:0] t;
    logic [DataW-1:0] target;
    logic [DataW-1:0] count;
    int unsigned n;
    t = IdxW'($urandom_range(0, Timers - 1));
    target = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 24)) : 16'($urandom);
    offer_beat(OP_WR_MODE, t, pick_mode());
    offer_beat(OP_WR_TARGET, t, target);
    case ($urandom_range(0, 3))
      0: count = target - 16'($urandom_range(0, 6));
      1: count = FULL_COUNT - 16'($urandom_range(0, 6));
      2: count = 16'($urandom);
      default: count = '0;
    endcase
    if (count != '0) offer_beat(OP_WR_COUNT, t, count);
    n = $urandom_range(4, 30);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) offer_beat(OP_RD_COUNT, pick_index(), 16'($urandom));
      else offer_beat(OP_TICK, pick_index(), 16'($urandom));
    end
    offer_beat(OP_RD_COUNT, t, 16'($urandom));
  endtask

  initial begin
    int unsigned stall_left;
    timer_result_t exp_res;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (irq_pulses_o != '0) irq_beats++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat: read_data %h irq_pulses %b", $time,
                   read_data_o, irq_pulses_o);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (read_data_o !== exp_res.rd) begin
            $display("%0t: read_data expected %h, got %h", $time, exp_res.rd, read_data_o);
            errors++;
          end
          if (irq_pulses_o !== exp_res.irq) begin
            $display("%0t: irq_pulses expected %b, got %b", $time, exp_res.irq, irq_pulses_o);
            errors++;
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 10);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned stop_at;
    logic [DataW-1:0] dot;
    logic [DataW-1:0] line;
    for (int t = 0; t < Timers; t++) begin
      tmr_count[t] = '0;
      tmr_prescale[t] = '0;
      tmr_mode[t] = '0;
      tmr_target[t] = '0;
      tmr_armed[t] = 1'b1;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i])
      offer_beat(DirRows[i].op, DirRows[i].idx, DirRows[i].val, DirRows[i].typed,
                 '{rd: DirRows[i].rd, irq: DirRows[i].irq});

    for (phase = 0; phase < 5; phase++) begin
      drain_results();
      case (phase)
        0: begin dot = 16'd1; line = 16'd1; end
        1: begin dot = 16'hffff; line = 16'hffff; end
        2: begin dot = 16'd0; line = 16'd3; end
        3: begin dot = 16'($urandom_range(2, 9)); line = 16'($urandom_range(2, 9)); end
        default: begin dot = 16'($urandom_range(1, 4)); line = 16'($urandom_range(1, 4)); end
      endcase
      write_dividers(dot, line);
      stop_at = beats_sent + PhaseBeats;
      if (phase == 0) begin
        // hold the output long enough for the unit to back up into its input
        hold_cycles = 80;
        quiet = 1'b1;
        repeat (30) offer_noise_beat();
        quiet = 1'b0;
      end
      quiet = (phase == 3);
      while (beats_sent < stop_at) begin
        if ($urandom_range(0, 3) != 0) run_timer_scenario();
        else offer_noise_beat();
      end
    end
    quiet = 1'b0;
    drain_results();
    repeat (6) @(posedge clk_i);

    $display("%0d beats driven (%0d count reads), %0d results checked, %0d with interrupts,",
             beats_sent, reads_sent, results_seen, irq_beats);
    $display("over reset dividers and five divider settings incl. 0, 1 and 0xffff");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
